### rtl/core/epla_pkg.sv
// ----------------------------------------------------------------------------
// epla_pkg
// Shared types and constants for the emergency priority lane arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package epla_pkg;

  localparam int DEF_LANES       = 4;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int CMD_W       = 3;
  localparam int LANE_W      = 2;
  localparam int AMOUNT_W    = 8;
  localparam int STEP_W      = 8;
  localparam int STATUS_W    = 3;
  localparam int GIDX_W      = 2;
  localparam int MASK_W      = 4;
  localparam int LCOUNT_W    = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 32;

  localparam logic [STEP_W-1:0] DRAIN_STEP_RESET = 8'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_EM_SET   = 3'd1,
    CMD_EM_CLR   = 3'd2,
    CMD_PED_ON   = 3'd3,
    CMD_PED_OFF  = 3'd4,
    CMD_EVALUATE = 3'd5,
    CMD_DRAIN    = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_GREEN    = 3'd1,
    ST_PED_BLOCK   = 3'd2,
    ST_EM_REASSIGN = 3'd3,
    ST_EM_ALL_RED  = 3'd4,
    ST_SATURATED   = 3'd5
  } status_t;

endpackage

`default_nettype wire

### rtl/core/epla_pick.sv
// ----------------------------------------------------------------------------
// epla_pick
// Highest nonzero count among the lanes not excluded, ties to lowest index.
// ----------------------------------------------------------------------------
`default_nettype none

module epla_pick #(
  parameter int LANES       = epla_pkg::DEF_LANES,
  parameter int COUNT_WIDTH = epla_pkg::DEF_COUNT_WIDTH,
  localparam int LW         = $clog2(LANES)
) (
  input  wire logic [COUNT_WIDTH-1:0] counts [LANES],
  input  wire logic [LANES-1:0]       excl,
  output logic                        found,
  output logic [LW-1:0]               index
);

  logic [LANES-1:0] elig;
  logic [LANES-1:0] win;

  // Every lane is compared against every other one in parallel; at most one
  // lane wins, so the encoder below only has to locate it.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      elig[i] = (counts[i] != '0) && !excl[i];
    end
    for (int i = 0; i < LANES; i++) begin
      win[i] = elig[i];
      for (int j = 0; j < LANES; j++) begin
        if (j < i) begin
          if (elig[j] && !(counts[i] > counts[j])) win[i] = 1'b0;
        end else if (j > i) begin
          if (elig[j] && !(counts[i] >= counts[j])) win[i] = 1'b0;
        end
      end
    end
    found = |win;
    index = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (win[i]) index = LW'(i);
    end
  end

endmodule

`default_nettype wire

### rtl/core/emergency_priority_lane_arbiter_top.sv
// ----------------------------------------------------------------------------
// emergency_priority_lane_arbiter_top
// Four-lane green-light arbiter with emergency and pedestrian priority.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transaction (command, lane, amount in tdata).
//   out_* : exactly one result per command, in command order.
//   cfg_* : drain_step register, written when cfg_wen is high.
// Timing: a command is captured in an input register, then evaluated against
//   the lane state in one pass of combinational logic that writes both the
//   state and the result register, which raises out_tvalid. Throughput is one
//   command per cycle while out_tready is high, set by the single
//   state-update pass (selection is a parallel compare matrix).
// Reset: counts, emergency flags, pedestrian flag and green lane clear,
//   all lights red, drain_step returns to 5. No results are pending.
// Stall: when a result waits and out_tready is low the result register holds; one more command
//   may wait in the input register, after which in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module emergency_priority_lane_arbiter_top #(
  parameter int LANES       = epla_pkg::DEF_LANES,
  parameter int COUNT_WIDTH = epla_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // [2:0] command, [4:3] lane, [12:5] amount, [15:13] zero
  input  wire logic [epla_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [2:0] status, [3] green_valid, [5:4] green_index, [6] pedestrian_waiting,
  // [10:7] emergency_mask, [26:11] lane_count, [31:27] zero
  output logic [epla_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_wen,
  input  wire logic [epla_pkg::STEP_W-1:0]     cfg_wdata
);

  import epla_pkg::*;

  localparam int LW = $clog2(LANES);
  localparam int CW = COUNT_WIDTH;

  // input register
  logic                s1_valid_r;
  cmd_t                s1_cmd_r;
  logic [LANE_W-1:0]   s1_lane_r;
  logic [AMOUNT_W-1:0] s1_amount_r;

  // lane state
  logic [CW-1:0]       cnt_r [LANES];
  logic [CW-1:0]       cnt_nxt [LANES];
  logic [LANES-1:0]    em_r, em_nxt;
  logic                gp_r, gp_nxt;
  logic [LW-1:0]       gl_r, gl_nxt;
  logic                ped_r, ped_nxt;
  logic [STEP_W-1:0]   step_r;

  // result register
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  logic                advance;
  logic                lane_ok;
  logic [LW-1:0]       lane_idx;
  logic [CW:0]         add_sum;
  logic [CW-1:0]       cnt_g, drained, count_out;
  logic [LANES-1:0]    g_onehot, pick_excl, em_cand, cnt_nz;
  logic                pick_found;
  logic [LW-1:0]       pick_index;
  status_t             status;
  logic [MASK_W-1:0]   mask_out;

  function automatic logic [LW-1:0] lowest(input logic [LANES-1:0] m);
    logic [LW-1:0] idx;
    idx = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (m[i]) idx = LW'(i);
    end
    return idx;
  endfunction

  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      cnt_nz[i] = cnt_r[i] != '0;
    end
  end

  assign lane_ok  = 32'(s1_lane_r) < LANES;
  assign lane_idx = LW'(s1_lane_r);
  assign cnt_g    = cnt_r[gl_r];
  assign g_onehot = LANES'(1) << gl_r;
  assign add_sum  = {1'b0, cnt_r[lane_idx]} + (CW + 1)'(s1_amount_r);
  assign drained  = (cnt_g >= CW'(step_r)) ? cnt_g - CW'(step_r) : '0;
  assign em_cand  = em_r & ~g_onehot & cnt_nz;

  // drain reassignment skips the drained lane; evaluate considers all lanes
  assign pick_excl = (s1_cmd_r == CMD_DRAIN) ? g_onehot : '0;

  epla_pick #(
    .LANES       (LANES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pick (
    .counts (cnt_r),
    .excl   (pick_excl),
    .found  (pick_found),
    .index  (pick_index)
  );

  always_comb begin
    cnt_nxt   = cnt_r;
    em_nxt    = em_r;
    gp_nxt    = gp_r;
    gl_nxt    = gl_r;
    ped_nxt   = ped_r;
    status    = ST_OK;
    count_out = '0;

    unique case (s1_cmd_r)
      CMD_ADD: begin
        if (lane_ok) begin
          if (add_sum[CW]) begin
            cnt_nxt[lane_idx] = '1;
            status            = ST_SATURATED;
          end else begin
            cnt_nxt[lane_idx] = add_sum[CW-1:0];
          end
        end
      end
      CMD_EM_SET: begin
        if (lane_ok) em_nxt[lane_idx] = 1'b1;
      end
      CMD_EM_CLR: begin
        if (lane_ok) em_nxt[lane_idx] = 1'b0;
      end
      CMD_PED_ON:  ped_nxt = 1'b1;
      CMD_PED_OFF: ped_nxt = 1'b0;
      CMD_EVALUATE: begin
        if (|em_r) begin
          gp_nxt = 1'b1;
          gl_nxt = lowest(em_r);
        end else if (ped_r) begin
          gp_nxt = 1'b0;
          status = ST_PED_BLOCK;
        end else if (pick_found) begin
          gp_nxt = 1'b1;
          gl_nxt = pick_index;
        end else begin
          gp_nxt = 1'b0;
          status = ST_NO_GREEN;
        end
      end
      CMD_DRAIN: begin
        if (ped_r) begin
          status = ST_PED_BLOCK;
          if (gp_r) count_out = cnt_g;
        end else if (!gp_r) begin
          status = ST_NO_GREEN;
        end else begin
          cnt_nxt[gl_r] = drained;
          count_out     = drained;
          if (drained == '0 && em_r[gl_r]) begin
            em_nxt[gl_r] = 1'b0;
            if (|em_cand) begin
              gl_nxt = lowest(em_cand);
              status = ST_EM_REASSIGN;
            end else if (pick_found) begin
              gl_nxt = pick_index;
              status = ST_EM_REASSIGN;
            end else begin
              gp_nxt = 1'b0;
              status = ST_EM_ALL_RED;
            end
          end
        end
      end
      default: ;
    endcase

    if (s1_cmd_r != CMD_DRAIN && lane_ok) count_out = cnt_nxt[lane_idx];

    mask_out = '0;
    for (int i = 0; i < LANES && i < MASK_W; i++) begin
      mask_out[i] = em_nxt[i];
    end

    out_data_nxt = {
      5'b0,
      LCOUNT_W'(count_out),
      mask_out,
      ped_nxt,
      gp_nxt ? GIDX_W'(gl_nxt) : GIDX_W'(0),
      gp_nxt,
      status
    };
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        cnt_r[i] <= '0;
      end
      em_r   <= '0;
      gp_r   <= 1'b0;
      gl_r   <= '0;
      ped_r  <= 1'b0;
      step_r <= DRAIN_STEP_RESET;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
        em_r        <= em_nxt;
        gp_r        <= gp_nxt;
        gl_r        <= gl_nxt;
        ped_r       <= ped_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wen) step_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r    <= cmd_t'(in_tdata[CMD_W-1:0]);
      s1_lane_r   <= in_tdata[CMD_W +: LANE_W];
      s1_amount_r <= in_tdata[CMD_W + LANE_W +: AMOUNT_W];
    end
    if (advance) out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
